>>> rtl/core/bdrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdrt_pkg
// Shared types and constants of the button debounce / release timer.
// ----------------------------------------------------------------------------
package bdrt_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int SAMPLE_W    = 10;
  localparam int STAMP_W     = 32;
  localparam int ID_W        = 8;
  localparam int DEBOUNCE_W  = 16;

  // analog level is 1 below this code
  localparam logic [SAMPLE_W-1:0] ANALOG_THRESHOLD = 10'd512;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_USE_ANALOG      = 2'd0,
    REG_DEBOUNCE_MS     = 2'd1,
    REG_HIGH_IS_PRESSED = 2'd2,
    REG_BUTTON_ID       = 2'd3
  } cfg_reg_t;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd50;

  typedef struct packed {
    logic                  use_analog;
    logic [DEBOUNCE_W-1:0] debounce_ms;
    logic                  high_is_pressed;
    logic [ID_W-1:0]       button_id;
  } cfg_t;

  typedef struct packed {
    logic               release_valid;
    logic [ID_W-1:0]    release_id;
    logic [STAMP_W-1:0] press_duration_ms;
    logic               stable_out;
    logic               pressed_out;
  } result_t;

endpackage

>>> rtl/core/bdrt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdrt_if
// Valid/ready channels: one for sample items, one for result items.
// ----------------------------------------------------------------------------
interface bdrt_sample_if
  import bdrt_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [STAMP_W-1:0]  now_ms;
  logic                digital_level;
  logic [SAMPLE_W-1:0] analog_sample;

  modport source (output valid, output now_ms, output digital_level,
                  output analog_sample, input ready);
  modport sink   (input valid, input now_ms, input digital_level,
                  input analog_sample, output ready);
endinterface

interface bdrt_result_if
  import bdrt_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               release_valid;
  logic [ID_W-1:0]    release_id;
  logic [STAMP_W-1:0] press_duration_ms;
  logic               stable_out;
  logic               pressed_out;

  modport source (output valid, output release_valid, output release_id,
                  output press_duration_ms, output stable_out,
                  output pressed_out, input ready);
  modport sink   (input valid, input release_valid, input release_id,
                  input press_duration_ms, input stable_out,
                  input pressed_out, output ready);
endinterface

>>> rtl/core/bdrt_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdrt_eval
// Per-item debounce update: raw level, hold check, stable change, release.
// ----------------------------------------------------------------------------
module bdrt_eval
  import bdrt_pkg::*;
#(
  parameter int TIME_WIDTH = 32
) (
  input  cfg_t                  cfg,
  input  logic [STAMP_W-1:0]    now_ms,
  input  logic                  digital_level,
  input  logic [SAMPLE_W-1:0]   analog_sample,
  input  logic                  raw_last,
  input  logic [TIME_WIDTH-1:0] raw_change_time,
  input  logic                  stable_level,
  input  logic [TIME_WIDTH-1:0] stable_since,
  input  logic                  pressed_flag,
  output logic                  raw_last_next,
  output logic [TIME_WIDTH-1:0] raw_change_time_next,
  output logic                  stable_level_next,
  output logic [TIME_WIDTH-1:0] stable_since_next,
  output logic                  pressed_flag_next,
  output result_t               res
);

  logic [63:0]           now_wide;
  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] held;
  logic [TIME_WIDTH-1:0] dur;
  logic [63:0]           dur_wide;
  logic                  level;
  logic                  take;
  logic                  rel;

  // timestamp truncated or zero-extended to the internal time width
  assign now_wide = {32'b0, now_ms};
  assign now_t    = now_wide[TIME_WIDTH-1:0];

  assign level = cfg.use_analog ? (analog_sample < ANALOG_THRESHOLD) : digital_level;

  assign raw_last_next        = level;
  assign raw_change_time_next = (level != raw_last) ? now_t : raw_change_time;

  assign held = now_t - raw_change_time_next;
  assign take = (held > TIME_WIDTH'(cfg.debounce_ms)) && (level != stable_level);
  assign rel  = take && pressed_flag;

  assign dur      = now_t - stable_since;
  assign dur_wide = 64'(dur);

  assign stable_level_next = take ? level : stable_level;
  assign stable_since_next = take ? now_t : stable_since;
  assign pressed_flag_next = take ? (level == cfg.high_is_pressed) : pressed_flag;

  always_comb begin
    res.release_valid     = rel;
    res.release_id        = rel ? cfg.button_id : '0;
    res.press_duration_ms = rel ? dur_wide[STAMP_W-1:0] : '0;
    res.stable_out        = stable_level_next;
    res.pressed_out       = pressed_flag_next;
  end

endmodule

>>> rtl/core/button_debounce_release_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_release_timer
// Debounces a digital or thresholded analog button level from timestamped
// samples and reports each pressed-to-released change with its duration.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+------------------------------------------
//  sample   | in  | valid / ready | now_ms, digital_level, analog_sample
//  result   | out | valid / ready | release_valid, release_id,
//           |     |               | press_duration_ms, stable_out, pressed_out
//  cfg      | in  | cfg_we        | cfg_index, cfg_data (write only)
//
//  Path: sample register, then debounce update into the result register.
//  One item per cycle while results are taken; the state update is a single pass.
//  Each stage moves when the next one is empty or being drained, so a held
//  result does not stop the sample register from filling.
//  rst (synchronous) clears state, stage valids and loads register defaults.
//  Debounce state updates only as an item moves into the result register.
//
module button_debounce_release_timer
  import bdrt_pkg::*;
#(
  parameter int TIME_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  bdrt_sample_if.sink            sample,
  bdrt_result_if.source          result
);

  // configuration registers
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.use_analog      <= 1'b0;
      cfg.debounce_ms     <= DEBOUNCE_RESET;
      cfg.high_is_pressed <= 1'b1;
      cfg.button_id       <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_USE_ANALOG:      cfg.use_analog      <= cfg_data[0];
        REG_DEBOUNCE_MS:     cfg.debounce_ms     <= cfg_data[DEBOUNCE_W-1:0];
        REG_HIGH_IS_PRESSED: cfg.high_is_pressed <= cfg_data[0];
        REG_BUTTON_ID:       cfg.button_id       <= cfg_data[ID_W-1:0];
        default: ;
      endcase
    end
  end

  // input stage
  logic                s1_valid;
  logic [STAMP_W-1:0]  s1_now;
  logic                s1_dig;
  logic [SAMPLE_W-1:0] s1_ana;
  logic                s1_adv;   // item moves into the result register
  logic                out_free; // result register can take an item

  assign out_free     = !result.valid || result.ready;
  assign s1_adv       = s1_valid && out_free;
  assign sample.ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.ready && sample.valid) begin
      s1_now <= sample.now_ms;
      s1_dig <= sample.digital_level;
      s1_ana <= sample.analog_sample;
    end
  end

  // debounce state
  logic                  raw_last;
  logic [TIME_WIDTH-1:0] raw_change_time;
  logic                  stable_level;
  logic [TIME_WIDTH-1:0] stable_since;
  logic                  pressed_flag;

  logic                  raw_last_next;
  logic [TIME_WIDTH-1:0] raw_change_time_next;
  logic                  stable_level_next;
  logic [TIME_WIDTH-1:0] stable_since_next;
  logic                  pressed_flag_next;
  result_t               res_next;

  bdrt_eval #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_eval (
    .cfg                  (cfg),
    .now_ms               (s1_now),
    .digital_level        (s1_dig),
    .analog_sample        (s1_ana),
    .raw_last             (raw_last),
    .raw_change_time      (raw_change_time),
    .stable_level         (stable_level),
    .stable_since         (stable_since),
    .pressed_flag         (pressed_flag),
    .raw_last_next        (raw_last_next),
    .raw_change_time_next (raw_change_time_next),
    .stable_level_next    (stable_level_next),
    .stable_since_next    (stable_since_next),
    .pressed_flag_next    (pressed_flag_next),
    .res                  (res_next)
  );

  // raw_last resets to the not-pressed level of the reset polarity (pressed high)
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_last        <= 1'b0;
      raw_change_time <= '0;
      stable_level    <= 1'b0;
      stable_since    <= '0;
      pressed_flag    <= 1'b0;
    end else if (s1_adv) begin
      raw_last        <= raw_last_next;
      raw_change_time <= raw_change_time_next;
      stable_level    <= stable_level_next;
      stable_since    <= stable_since_next;
      pressed_flag    <= pressed_flag_next;
    end
  end

  // result register
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_free) begin
      result.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res <= res_next;
    end
  end

  assign result.release_valid     = res.release_valid;
  assign result.release_id        = res.release_id;
  assign result.press_duration_ms = res.press_duration_ms;
  assign result.stable_out        = res.stable_out;
  assign result.pressed_out       = res.pressed_out;

  // checks
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !s1_adv |=> ($stable(stable_level) && $stable(stable_since) && $stable(raw_last)))
    else $error("debounce state changed with no item moving");

  a_item_lands: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> result.valid)
    else $error("item lost between sample and result register");

  a_no_event_payload: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.release_valid) |->
      (result.release_id == '0 && result.press_duration_ms == '0))
    else $error("release payload set without release event");

  a_out_mirrors_state: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> (result.stable_out == stable_level && result.pressed_out == pressed_flag))
    else $error("result level disagrees with debounce state");

endmodule

>>> tb/tb_button_debounce_release_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_debounce_release_timer
// Self-checking bench for the button debounce / release timer. A scoreboard
// keeps its own copy of the debounce state, predicts one result per accepted
// sample and checks every result field in order. Stimulus is a directed
// opening followed by randomized press/release gestures with contact bounce,
// cut-short presses and timestamp noise, over six register settings and
// three idle profiles on the two channels.
// ----------------------------------------------------------------------------
module tb_button_debounce_release_timer;
  import bdrt_pkg::*;

  localparam int          CLK_HALF    = 6;       // 12 ns period
  localparam int unsigned CYCLE_LIMIT = 400000;  // watchdog bound on the run
  localparam int unsigned LONG_STALL  = 400;     // receiver hold-off, in cycles

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the debounce state and holds the expected results.
  // --------------------------------------------------------------------------
  class debounce_scoreboard;
    cfg_t               cfg;
    logic               raw_level;
    logic [STAMP_W-1:0] raw_change_ms;
    logic               stable_level;
    logic [STAMP_W-1:0] stable_since_ms;
    logic               pressed;
    result_t            expected_q[$];
    int unsigned        errors;
    int unsigned        checked;

    function new();
      cfg             = '{use_analog: 1'b0, debounce_ms: DEBOUNCE_RESET,
                          high_is_pressed: 1'b1, button_id: '0};
      // raw level starts at the not-pressed level of the reset polarity
      raw_level       = 1'b0;
      raw_change_ms   = '0;
      stable_level    = 1'b0;
      stable_since_ms = '0;
      pressed         = 1'b0;
      errors          = 0;
      checked         = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Advance the debounce state by one accepted sample.
    function void note_sample(logic [STAMP_W-1:0] now, logic dig, logic [SAMPLE_W-1:0] ana);
      logic               level;
      logic [STAMP_W-1:0] held;
      result_t            want;
      want  = '0;
      level = cfg.use_analog ? (ana < ANALOG_THRESHOLD) : dig;
      if (level != raw_level) begin
        raw_change_ms = now;
        raw_level     = level;
      end
      held = now - raw_change_ms;
      if (held > STAMP_W'(cfg.debounce_ms) && level != stable_level) begin
        if (pressed) begin
          want.release_valid     = 1'b1;
          want.release_id        = cfg.button_id;
          want.press_duration_ms = now - stable_since_ms;
        end
        stable_level    = level;
        stable_since_ms = now;
        pressed         = (stable_level == cfg.high_is_pressed);
      end
      want.stable_out  = stable_level;
      want.pressed_out = pressed;
      expected_q.push_back(want);
    endfunction

    task report(string what);
      if (errors < 100)
        $display("[%0t] MISMATCH: %s", $time, what);
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report("result item with no sample outstanding");
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.release_valid !== want.release_valid)
        report($sformatf("result %0d release_valid %b, expected %b",
                         checked, got.release_valid, want.release_valid));
      if (got.release_id !== want.release_id)
        report($sformatf("result %0d release_id %h, expected %h",
                         checked, got.release_id, want.release_id));
      if (got.press_duration_ms !== want.press_duration_ms)
        report($sformatf("result %0d press_duration_ms %h, expected %h",
                         checked, got.press_duration_ms, want.press_duration_ms));
      if (got.stable_out !== want.stable_out)
        report($sformatf("result %0d stable_out %b, expected %b",
                         checked, got.stable_out, want.stable_out));
      if (got.pressed_out !== want.pressed_out)
        report($sformatf("result %0d pressed_out %b, expected %b",
                         checked, got.pressed_out, want.pressed_out));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels, block
  // --------------------------------------------------------------------------
  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  bdrt_sample_if sample_ch ();
  bdrt_result_if result_ch ();

  button_debounce_release_timer u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .result    (result_ch)
  );

  debounce_scoreboard sb = new();

  cfg_t               cur;            // settings the stimulus is shaped for
  logic [STAMP_W-1:0] t_ms;           // running timestamp of the sample stream
  int unsigned        items_sent;
  int unsigned        send_idle_pct;  // only the stimulus process touches this
  int unsigned        recv_idle_pct;  // written with NBAs, read by the receiver
  logic               stall_go;       // toggled to request one long hold-off
  int unsigned        cycle_count;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result side: checks each accepted result item, then picks ready for the
  // next cycle. A toggle of stall_go starts a long hold-off counted here.
  // --------------------------------------------------------------------------
  initial begin : result_side
    int unsigned hold_left;
    logic        stall_seen;
    result_t     got;
    hold_left       = 0;
    stall_seen      = 1'b0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        got.release_valid     = result_ch.release_valid;
        got.release_id        = result_ch.release_id;
        got.press_duration_ms = result_ch.press_duration_ms;
        got.stable_out        = result_ch.stable_out;
        got.pressed_out       = result_ch.pressed_out;
        sb.check_result(got);
      end
      if (stall_go != stall_seen) begin
        stall_seen = stall_go;
        hold_left  = LONG_STALL;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sample side
  // --------------------------------------------------------------------------

  // Offer one item; valid stays high after acceptance so back-to-back items
  // need no extra NBA on valid in the accepting step.
  task automatic send_sample(input logic [STAMP_W-1:0] now, input logic dig,
                             input logic [SAMPLE_W-1:0] ana);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid         <= 1'b1;
    sample_ch.now_ms        <= now;
    sample_ch.digital_level <= dig;
    sample_ch.analog_sample <= ana;
    do @(posedge clk); while (!sample_ch.ready);
    sb.note_sample(now, dig, ana);
    items_sent++;
  endtask

  // Drop valid and wait for every outstanding result item.
  task automatic wait_drained();
    sample_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Registers change only with the block empty, after a pause.
  task automatic apply_config(input cfg_t c);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_USE_ANALOG;
    cfg_data  <= CFG_DATA_W'(c.use_analog);
    @(posedge clk);
    cfg_index <= REG_DEBOUNCE_MS;
    cfg_data  <= c.debounce_ms;
    @(posedge clk);
    cfg_index <= REG_HIGH_IS_PRESSED;
    cfg_data  <= CFG_DATA_W'(c.high_is_pressed);
    @(posedge clk);
    cfg_index <= REG_BUTTON_ID;
    cfg_data  <= CFG_DATA_W'(c.button_id);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.cfg = c;
    cur    = c;
  endtask

  function automatic cfg_t make_cfg(logic analog, logic [DEBOUNCE_W-1:0] deb, logic hip,
                                    logic [ID_W-1:0] id);
    return '{use_analog: analog, debounce_ms: deb, high_is_pressed: hip, button_id: id};
  endfunction

  // Send a sample whose raw level is lvl under the current mode; the unused
  // input carries random content. Analog picks hit the threshold edges often.
  task automatic send_level(input logic lvl, input logic [STAMP_W-1:0] stamp);
    logic                dig;
    logic [SAMPLE_W-1:0] ana;
    t_ms = stamp;
    if (cur.use_analog) begin
      dig = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 7))
        0:       ana = lvl ? 10'd511 : 10'd512;
        1:       ana = lvl ? 10'd0   : 10'd1023;
        default: ana = lvl ? 10'($urandom_range(0, 511)) : 10'($urandom_range(512, 1023));
      endcase
    end else begin
      dig = lvl;
      ana = 10'($urandom_range(0, 1023));
    end
    send_sample(stamp, dig, ana);
  endtask

  // One button movement toward raw level lvl: bounce, then a hold that
  // passes the debounce time (sometimes landing exactly on it first).
  // Now and then the hold is cut short.
  task automatic move_button(input logic lvl);
    int unsigned        deb;
    int unsigned        step;
    logic [STAMP_W-1:0] start;
    deb  = 32'(cur.debounce_ms);
    step = deb / 3 + 1;
    repeat ($urandom_range(0, 5))
      send_level(1'($urandom_range(0, 1)), t_ms + $urandom_range(0, step));
    send_level(lvl, t_ms + $urandom_range(1, step));
    start = t_ms;
    repeat ($urandom_range(0, 2))
      send_level(lvl, t_ms + $urandom_range(0, deb / 4));
    if ($urandom_range(0, 7) == 0)
      return;
    if ($urandom_range(0, 3) == 0)
      send_level(lvl, start + deb);                // held == debounce, no change
    send_level(lvl, start + deb + 1 + $urandom_range(0, 3));
    repeat ($urandom_range(0, 2))
      send_level(lvl, t_ms + $urandom_range(0, step));
  endtask

  // Random level at a random time; a quarter jump anywhere in the stamp range.
  task automatic noise_item();
    if ($urandom_range(0, 3) == 0)
      send_level(1'($urandom_range(0, 1)), $urandom);
    else
      send_level(1'($urandom_range(0, 1)),
                 t_ms + $urandom_range(0, 2 * cur.debounce_ms + 2));
  endtask

  // Mostly press/release pairs, the rest noise.
  task automatic drive_traffic(input int unsigned n_items);
    int unsigned target;
    target = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(0, 3) == 0) begin
        noise_item();
      end else begin
        move_button(cur.high_is_pressed);
        move_button(~cur.high_is_pressed);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rst                     = 1'b1;
    cfg_we                  = 1'b0;
    cfg_index               = REG_USE_ANALOG;
    cfg_data                = '0;
    sample_ch.valid         = 1'b0;
    sample_ch.now_ms        = '0;
    sample_ch.digital_level = 1'b0;
    sample_ch.analog_sample = '0;
    send_idle_pct           = 0;
    recv_idle_pct           = 0;
    stall_go                = 1'b0;
    items_sent              = 0;
    t_ms                    = '0;
    cur                     = sb.cfg;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: polarity flipped right after reset. The raw level keeps its
    // reset value, level 0 is already stable but not yet flagged pressed,
    // and going into the pressed state reports nothing.
    apply_config(make_cfg(1'b0, 16'd50, 1'b0, 8'h5A));
    send_sample(32'd0,   1'b0, 10'd0);
    send_sample(32'd51,  1'b0, 10'd1023);
    send_sample(32'd60,  1'b1, 10'd0);
    send_sample(32'd111, 1'b1, 10'd1023);   // stable 1, not pressed
    send_sample(32'd120, 1'b0, 10'd0);
    send_sample(32'd171, 1'b0, 10'd1023);   // stable 0, now pressed, no event
    send_sample(32'd200, 1'b1, 10'd0);
    send_sample(32'd250, 1'b1, 10'd1023);   // held exactly 50: no change yet
    send_sample(32'd251, 1'b1, 10'd0);      // release after 80 ms

    // Analog with zero debounce, across the stamp wrap. The digital pin is
    // driven opposite the analog level on the first four items to show it is
    // ignored; a raw change never becomes stable on its own item.
    apply_config(make_cfg(1'b1, 16'd0, 1'b1, 8'hFF));
    send_sample(32'hFFFF_FFF0, 1'b1, 10'd1023);
    send_sample(32'hFFFF_FFF1, 1'b1, 10'd512);
    send_sample(32'hFFFF_FFFF, 1'b0, 10'd511);
    send_sample(32'h0000_0002, 1'b0, 10'd0);  // pressed, hold wrapped
    send_sample(32'h0000_0005, 1'b0, 10'd512);
    send_sample(32'h0000_0005, 1'b0, 10'd512);
    send_sample(32'h0000_0006, 1'b0, 10'd512);  // release after 4 ms

    // Largest debounce time and a press lasting over 2^31 ms.
    apply_config(make_cfg(1'b0, 16'hFFFF, 1'b1, 8'h00));
    send_sample(32'd100,        1'b1, 10'd512);
    send_sample(32'd65635,      1'b1, 10'd512);
    send_sample(32'd65636,      1'b1, 10'd512);
    send_sample(32'h8001_0064,  1'b0, 10'd512);
    send_sample(32'h8002_0064,  1'b0, 10'd512);

    // Sender mostly busy, receiver mostly stalled.
    send_idle_pct = 14;
    recv_idle_pct <= 86;
    apply_config(make_cfg(1'b0, 16'($urandom_range(0, 40)), 1'b1, 8'($urandom_range(0, 255))));
    drive_traffic(320);
    apply_config(make_cfg(1'b1, 16'd0, 1'b0, 8'hFF));
    drive_traffic(320);

    // The other way round.
    send_idle_pct = 86;
    recv_idle_pct <= 14;
    apply_config(make_cfg(1'b0, 16'($urandom_range(0, 3000)), 1'b0, 8'h00));
    drive_traffic(320);
    apply_config(make_cfg(1'b1, 16'($urandom_range(1, 200)), 1'b1,
                          8'($urandom_range(0, 255))));
    drive_traffic(320);

    // No idling. Midway the receiver holds off long enough for the block to
    // back up into the sample channel; later the sender stops until all
    // results are back.
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    apply_config(make_cfg(1'b0, 16'hFFFF, 1'b1, 8'($urandom_range(0, 255))));
    drive_traffic(100);
    stall_go <= ~stall_go;
    drive_traffic(100);
    wait_drained();
    drive_traffic(120);
    apply_config(make_cfg(1'b1, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                          8'($urandom_range(0, 255))));
    drive_traffic(320);

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
